// File: rtl/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // result control that travels with each completed operation
  typedef struct packed {
    logic    strobe;
    logic    pop_ok;
    status_t status;
  } res_ctl_t;

endpackage
`default_nettype wire

// File: rtl/dq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Single-port word store with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module dq_ram
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic                    re,
  input  wire logic [AW-1:0]           addr,
  input  wire logic signed [WordW-1:0] wdata,
  output logic signed [WordW-1:0]      rdata
);

  logic signed [WordW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Head, tail and fill count of the ring; decodes each operation into at most one
// store access and the result control for the following cycle.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [1:0]    func,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output res_ctl_t           res,
  output logic [CW-1:0]      occupancy
);

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  res_ctl_t      res_next;
  logic          full, empty;
  op_t           op;

  assign full  = (count == FullCnt);
  assign empty = (count == '0);
  assign op    = op_t'(func);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = '0;
    res_next.strobe = accept;
    res_next.pop_ok = 1'b0;
    res_next.status = ST_DONE;
    if (accept) begin
      unique case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          priority if (full) begin
            res_next.status = ST_OVERFLOW;
          end else if (empty) begin
            head_next  = '0;
            tail_next  = '0;
            mem_we     = 1'b1;
            mem_addr   = '0;
            count_next = CW'(1);
          end else if (op == OP_PUSH_FRONT) begin
            head_next  = (head == '0) ? LastIdx : head - AW'(1);
            mem_we     = 1'b1;
            mem_addr   = head_next;
            count_next = count + CW'(1);
          end else begin
            tail_next  = (tail == LastIdx) ? '0 : tail + AW'(1);
            mem_we     = 1'b1;
            mem_addr   = tail_next;
            count_next = count + CW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            res_next.status = ST_UNDERFLOW;
          end else begin
            mem_re          = 1'b1;
            res_next.pop_ok = 1'b1;
            mem_addr        = (op == OP_POP_FRONT) ? head : tail;
            priority if (count == CW'(1)) begin
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
            end else if (op == OP_POP_FRONT) begin
              head_next  = (head == LastIdx) ? '0 : head + AW'(1);
              count_next = count - CW'(1);
            end else begin
              tail_next  = (tail == '0) ? LastIdx : tail - AW'(1);
              count_next = count - CW'(1);
            end
          end
        end
        default: begin
          res_next.strobe = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      res       <= '0;
      occupancy <= '0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      res       <= res_next;
      occupancy <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed words: push or pop at either end.
// ----------------------------------------------------------------------------
// Takes one operation every clock cycle (busy is high only during reset). The
// result of an operation appears on the cycle after its transfer, marked by
// done, for exactly one cycle; the receiver cannot stall it. The popped word
// comes from the registered read of the single-port word store, which sees
// at most one access per operation. Storage holds DEPTH words; occupancy is
// $clog2(DEPTH+1) bits wide.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              func,
  input  wire logic signed [WordW-1:0] value,
  output logic                         done,
  output logic signed [WordW-1:0]      popped_value,
  output logic [1:0]                   status,
  output logic [CW-1:0]                occupancy,
  output logic                         is_empty_flag
);

  logic                    accept;
  logic                    mem_we;
  logic                    mem_re;
  logic [AW-1:0]           mem_addr;
  logic signed [WordW-1:0] mem_rdata;
  res_ctl_t                res;

  assign busy   = rst;
  assign accept = start && !busy;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (func),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .res       (res),
    .occupancy (occupancy)
  );

  dq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (value),
    .rdata (mem_rdata)
  );

  assign done          = res.strobe;
  assign status        = res.status;
  assign popped_value  = res.pop_ok ? mem_rdata : '0;
  assign is_empty_flag = (occupancy == '0);

endmodule
`default_nettype wire

// File: rtl/dq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque's transfers and results.
// ----------------------------------------------------------------------------
module dq_checker
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    done,
  input wire logic signed [WordW-1:0] popped_value,
  input wire logic [1:0]              status,
  input wire logic [CW-1:0]           occupancy,
  input wire logic                    is_empty_flag
);

  a_one_result: assert property (@(posedge clk)
    (!rst && start && !busy) |=> done)
    else $error("transfer without a result");

  a_no_stray_result: assert property (@(posedge clk)
    (rst || !start || busy) |=> !done)
    else $error("result without a transfer");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty_flag == (occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OVERFLOW) |-> (occupancy == CW'(DEPTH) && popped_value == '0))
    else $error("overflow while not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_UNDERFLOW) |-> (occupancy == '0 && popped_value == '0))
    else $error("underflow while not empty");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
`default_nettype wire
